/* hdl/tlb_page_translation_unit_defines.svh */
// Assertion macros shared by the translation unit RTL.
`ifndef TLB_PAGE_TRANSLATION_UNIT_DEFINES_SVH
`define TLB_PAGE_TRANSLATION_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TPTU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TPTU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tptu_pkg.sv */
`default_nettype none

package tptu_pkg;

  // Address width of both the logical and the physical address
  localparam int unsigned ADDR_WIDTH = 16;

  // Default geometry
  localparam int unsigned TLB_ENTRIES_DEF  = 16;
  localparam int unsigned PAGE_COUNT_DEF   = 256;
  localparam int unsigned OFFSET_WIDTH_DEF = 8;

  // Page table access command
  typedef struct packed {
    logic rd;
    logic wr;
  } pt_cmd_t;

  // Page table status
  typedef struct packed {
    logic ready;   // clearing pass done
    logic mapped;  // mapped flag of the last read entry
  } pt_stat_t;

endpackage

`default_nettype wire

/* hdl/tptu_tlb.sv */
`default_nettype none

module tptu_tlb #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [$clog2(PAGE_COUNT)-1:0] page_i,
  input  wire logic                          ins_en_i,
  input  wire logic [$clog2(PAGE_COUNT)-1:0] ins_frame_i,
  output logic                               hit_o,
  output logic      [$clog2(PAGE_COUNT)-1:0] frame_o
);

  localparam int unsigned PW = $clog2(PAGE_COUNT);
  localparam int unsigned IW = $clog2(TLB_ENTRIES);

  logic [PW-1:0] tag_q   [TLB_ENTRIES];
  logic [PW-1:0] frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid_q;
  logic [IW-1:0] ptr_q;
  logic [IW-1:0] ptr_d;

  // Search all valid entries; the lowest matching entry wins
  always_comb begin
    hit_o   = 1'b0;
    frame_o = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (tag_q[i] == page_i)) begin
        hit_o   = 1'b1;
        frame_o = frame_q[i];
      end
    end
  end

  // Advance the FIFO insert pointer with wrap
  assign ptr_d = (ptr_q == IW'(TLB_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;

  // Hold valid bits and insert pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else if (ins_en_i) begin
      valid_q[ptr_q] <= 1'b1;
      ptr_q          <= ptr_d;
    end
  end

  // Write tag and frame of the inserted entry
  always_ff @(posedge clk_i) begin
    if (ins_en_i) begin
      tag_q[ptr_q]   <= page_i;
      frame_q[ptr_q] <= ins_frame_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/tptu_page_table.sv */
`default_nettype none

module tptu_page_table #(
  parameter int unsigned PAGE_COUNT = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tptu_pkg::pt_cmd_t             cmd_i,
  input  wire logic [$clog2(PAGE_COUNT)-1:0] page_i,
  input  wire logic [$clog2(PAGE_COUNT)-1:0] wr_frame_i,
  output tptu_pkg::pt_stat_t                 stat_o,
  output logic      [$clog2(PAGE_COUNT)-1:0] rd_frame_o
);

  import tptu_pkg::*;

  localparam int unsigned PW = $clog2(PAGE_COUNT);

  // Each word holds {mapped, frame}
  logic [PW:0]   mem [PAGE_COUNT];
  logic [PW:0]   rdata_q;
  logic          clr_q;
  logic [PW-1:0] clr_idx_q;
  logic          we;
  logic [PW-1:0] waddr;
  logic [PW:0]   wdata;

  // Clearing pass owns the write port until every entry is unmapped
  assign we    = clr_q || cmd_i.wr;
  assign waddr = clr_q ? clr_idx_q : page_i;
  assign wdata = clr_q ? '0 : {1'b1, wr_frame_i};

  // Sweep the memory once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      if (clr_idx_q == PW'(PAGE_COUNT - 1)) begin
        clr_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // Single-port style memory with registered read data
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[page_i];
    end
  end

  assign stat_o.ready  = !clr_q;
  assign stat_o.mapped = rdata_q[PW];
  assign rd_frame_o    = rdata_q[PW-1:0];

`include "tlb_page_translation_unit_defines.svh"

  `TPTU_ASSERT_SAME(a_no_access_in_clear, cmd_i.rd || cmd_i.wr, !clr_q, "access during clear")
  `TPTU_ASSERT_NEXT(a_clear_ends, clr_q && clr_idx_q == PW'(PAGE_COUNT - 1), !clr_q, "clear overrun")
  `TPTU_ASSERT_NEXT(a_clear_once, !clr_q, !clr_q, "clearing pass restarted")

endmodule

`default_nettype wire

/* hdl/tlb_page_translation_unit.sv */
// Channel  | Direction | Beat fields                                | Handshake
// ---------+-----------+--------------------------------------------+-----------------------
// in       | input     | logical_address_i                          | in_valid_i / in_stall_o
// out      | output    | physical_address_o, tlb_hit_o, page_fault_o| out_valid_o / out_stall_i
//
// A TLB hit passes through capture and CAM search; a miss passes through capture, page table
// read, and allocate and write back, the extra step set by the registered page table RAM read.
// After reset the page table is swept once with in_stall_o held high.
// One beat is in flight at a time; the result register lets the next beat enter while a
// result waits, and a stalled output holds the finishing step until the register frees up.
`default_nettype none

module tlb_page_translation_unit #(
  parameter int unsigned TLB_ENTRIES  = tptu_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_COUNT   = tptu_pkg::PAGE_COUNT_DEF,
  parameter int unsigned OFFSET_WIDTH = tptu_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [tptu_pkg::ADDR_WIDTH-1:0] logical_address_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [tptu_pkg::ADDR_WIDTH-1:0] physical_address_o,
  output logic                                 tlb_hit_o,
  output logic                                 page_fault_o
);

  import tptu_pkg::*;

  localparam int unsigned PW    = $clog2(PAGE_COUNT);
  localparam int unsigned RAW_W = (ADDR_WIDTH > OFFSET_WIDTH) ? ADDR_WIDTH - OFFSET_WIDTH : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_WALK
  } state_e;

  state_e                  state_q, state_d;
  logic [RAW_W-1:0]        raw_page;
  logic [PW-1:0]           page_in;
  logic [PW-1:0]           page_q;
  logic [OFFSET_WIDTH-1:0] offset_q;
  logic [PW-1:0]           next_frame_q;
  logic [PW-1:0]           next_frame_d;
  logic                    out_valid_q;
  logic [ADDR_WIDTH-1:0]   phys_q;
  logic                    hit_q;
  logic                    fault_q;
  logic                    in_acc;
  logic                    out_free;
  logic                    res_load;
  logic                    res_hit;
  logic                    res_fault;
  logic [PW-1:0]           res_frame;
  logic                    tlb_hit;
  logic [PW-1:0]           tlb_frame;
  logic                    tlb_ins;
  pt_cmd_t                 pt_cmd;
  pt_stat_t                pt_stat;
  logic [PW-1:0]           pt_frame;

  // Split the address; an offset covering the whole address leaves page 0
  assign raw_page = RAW_W'(logical_address_i >> OFFSET_WIDTH);

  // Reduce the page number into the page table range
  if ((1 << PW) == PAGE_COUNT) begin : g_pow2
    assign page_in = PW'(raw_page);
  end else begin : g_mod
    logic [PW:0] rem;
    always_comb begin
      rem = '0;
      for (int i = RAW_W - 1; i >= 0; i--) begin
        rem = {rem[PW-1:0], raw_page[i]};
        if (rem >= (PW + 1)'(PAGE_COUNT)) begin
          rem = rem - (PW + 1)'(PAGE_COUNT);
        end
      end
      page_in = rem[PW-1:0];
    end
  end

  tptu_tlb #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_tlb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .page_i     (page_q),
    .ins_en_i   (tlb_ins),
    .ins_frame_i(res_frame),
    .hit_o      (tlb_hit),
    .frame_o    (tlb_frame)
  );

  tptu_page_table #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_page_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (pt_cmd),
    .page_i    (page_q),
    .wr_frame_i(next_frame_q),
    .stat_o    (pt_stat),
    .rd_frame_o(pt_frame)
  );

  // Handshake terms
  assign in_stall_o = !((state_q == S_IDLE) && pt_stat.ready);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequence one beat: search, then on a miss walk, refill the TLB and allocate a frame if unmapped
  always_comb begin
    state_d   = state_q;
    pt_cmd    = '0;
    tlb_ins   = 1'b0;
    res_load  = 1'b0;
    res_hit   = 1'b0;
    res_fault = 1'b0;
    res_frame = tlb_frame;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (tlb_hit) begin
          if (out_free) begin
            res_load = 1'b1;
            res_hit  = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          pt_cmd.rd = 1'b1;
          state_d   = S_WALK;
        end
      end
      S_WALK: begin
        res_frame = pt_stat.mapped ? pt_frame : next_frame_q;
        if (out_free) begin
          res_load  = 1'b1;
          res_fault = !pt_stat.mapped;
          pt_cmd.wr = !pt_stat.mapped;
          tlb_ins   = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Advance the free frame counter with wrap
  assign next_frame_d = (next_frame_q == PW'(PAGE_COUNT - 1)) ? '0 : next_frame_q + 1'b1;

  // Hold state, captured beat, allocator and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      page_q       <= '0;
      offset_q     <= '0;
      next_frame_q <= '0;
      out_valid_q  <= 1'b0;
      phys_q       <= '0;
      hit_q        <= 1'b0;
      fault_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        page_q   <= page_in;
        offset_q <= logical_address_i[OFFSET_WIDTH-1:0];
      end
      if (pt_cmd.wr) begin
        next_frame_q <= next_frame_d;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
        phys_q      <= ADDR_WIDTH'({res_frame, offset_q});
        hit_q       <= res_hit;
        fault_q     <= res_fault;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = phys_q;
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;

`include "tlb_page_translation_unit_defines.svh"

  `TPTU_ASSERT_SAME(a_hit_no_fault, out_valid_o, !(tlb_hit_o && page_fault_o), "hit with fault")
  `TPTU_ASSERT_SAME(a_accept_idle, in_acc, state_q == S_IDLE && pt_stat.ready, "accept while busy")
  `TPTU_ASSERT_SAME(a_insert_on_miss, tlb_ins, !tlb_hit && state_q == S_WALK, "insert on hit")
  `TPTU_ASSERT_NEXT(a_alloc_advance, pt_cmd.wr, next_frame_q != $past(next_frame_q), "frame reused")

endmodule

`default_nettype wire
